// ----- hw/rtl/cta_pkg.sv -----
// ----------------------------------------------------------------------------
// cta_pkg
// shared types and constants of the credit token allocator
// ----------------------------------------------------------------------------
package cta_pkg;

    localparam int unsigned FIELD_W   = 8;
    localparam int unsigned ID_W      = 4;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned ID_SPAN   = 1 << ID_W;

    localparam logic [FIELD_W-1:0] TOTAL_RESET = 8'd8;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- hw/rtl/credit_token_allocator.sv -----
// ----------------------------------------------------------------------------
// credit_token_allocator
// shared token pool with a per-client holding table
//
//   channel  handshake          payload
//   input    start / busy       i_func i_client_id i_client_live i_cost
//   result   o_valid (strobe)   o_ok o_cost_fits o_attacker_count
//                               o_tokens_available
//   config   i_cfg_we           i_cfg_wdata (total_tokens)
//
// a transaction is a capture, then one read-modify-write step of
// the holding table, pool adder and compare; busy is high during that step
// the result strobes for one cycle, in which the next transaction can start
// reset or a config write sets the pool to total_tokens; reset clears holders
// the receiver cannot stall, so nothing backs up on the result side
// ----------------------------------------------------------------------------
module credit_token_allocator
    import cta_pkg::*;
#(
    parameter int unsigned MAX_CLIENTS = 16
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [ID_W-1:0]    i_client_id,
    input  logic               i_client_live,
    input  logic [FIELD_W-1:0] i_cost,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_wdata,
    output logic               o_valid,
    output logic               o_ok,
    output logic               o_cost_fits,
    output logic [COUNT_W-1:0] o_attacker_count,
    output logic [FIELD_W-1:0] o_tokens_available
);

    t_dp_cmd cmd;

    cta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    cta_dp #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_func             (i_func),
        .i_client_id        (i_client_id),
        .i_client_live      (i_client_live),
        .i_cost             (i_cost),
        .o_ok               (o_ok),
        .o_cost_fits        (o_cost_fits),
        .o_attacker_count   (o_attacker_count),
        .o_tokens_available (o_tokens_available)
    );

endmodule

// ----- hw/rtl/cta_ctrl.sv -----
// ----------------------------------------------------------------------------
// cta_ctrl
// sequencer: takes a transaction, runs one update step, strobes the result
// ----------------------------------------------------------------------------
module cta_ctrl
    import cta_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy          = (r_state == S_EXEC);
    assign o_valid       = r_done;
    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

// ----- hw/rtl/cta_dp.sv -----
// ----------------------------------------------------------------------------
// cta_dp
// pool level, holding table and result registers
// ----------------------------------------------------------------------------
module cta_dp
    import cta_pkg::*;
#(
    parameter int unsigned MAX_CLIENTS = 16
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_wdata,
    input  logic               i_func,
    input  logic [ID_W-1:0]    i_client_id,
    input  logic               i_client_live,
    input  logic [FIELD_W-1:0] i_cost,
    output logic               o_ok,
    output logic               o_cost_fits,
    output logic [COUNT_W-1:0] o_attacker_count,
    output logic [FIELD_W-1:0] o_tokens_available
);

    localparam int unsigned DEPTH = (MAX_CLIENTS < ID_SPAN) ? MAX_CLIENTS : ID_SPAN;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               r_func;
    logic [ID_W-1:0]    r_id;
    logic               r_live;
    logic [FIELD_W-1:0] r_cost;

    logic [FIELD_W-1:0] r_total;
    logic [FIELD_W-1:0] r_pool;
    logic [COUNT_W-1:0] r_count;
    logic [FIELD_W-1:0] r_held [DEPTH];
    logic [DEPTH-1:0]   r_vld;

    logic               r_ok;
    logic               r_fits;

    logic [IDX_W-1:0]   idx;
    logic               live;
    logic               ent_vld;
    logic [FIELD_W-1:0] ent_held;
    logic [FIELD_W:0]   sum;
    logic               gb_ok;
    logic [FIELD_W-1:0] pool1;
    logic               vld1;
    logic [COUNT_W-1:0] count1;
    logic               fits;
    logic               grant;
    logic [FIELD_W-1:0] n_pool;
    logic [COUNT_W-1:0] n_count;
    logic               n_ok;

    assign idx      = r_id[IDX_W-1:0];
    assign live     = r_live && ({1'b0, r_id} < (ID_W+1)'(DEPTH));
    assign ent_vld  = r_vld[idx];
    assign ent_held = r_held[idx];
    assign sum      = {1'b0, r_pool} + {1'b0, ent_held};
    assign gb_ok    = live && ent_vld && (sum <= {1'b0, r_total});
    assign pool1    = gb_ok ? sum[FIELD_W-1:0] : r_pool;
    assign vld1     = ent_vld && !gb_ok;
    assign count1   = (gb_ok && (r_count != '0)) ? r_count - 1'b1 : r_count;
    assign fits     = (r_pool != '0) && (r_pool >= r_cost);
    assign grant    = (r_func == FUNC_REQUEST) && live && (pool1 != '0) && (pool1 >= r_cost);
    assign n_pool   = grant ? pool1 - r_cost : pool1;
    assign n_count  = (grant && !vld1) ? count1 + 1'b1 : count1;
    assign n_ok     = (r_func == FUNC_REQUEST) ? grant : gb_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_id   <= i_client_id;
            r_live <= i_client_live;
            r_cost <= i_cost;
        end
        if (i_cmd.exec) begin
            r_ok   <= n_ok;
            r_fits <= (r_func == FUNC_REQUEST) && fits;
            if (grant) begin
                r_held[idx] <= r_cost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
            r_pool  <= TOTAL_RESET;
            r_count <= '0;
            r_vld   <= '0;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_wdata;
            r_pool  <= i_cfg_wdata;
        end else if (i_cmd.exec) begin
            r_pool  <= n_pool;
            r_count <= n_count;
            if (grant) begin
                r_vld[idx] <= 1'b1;
            end else if (gb_ok) begin
                r_vld[idx] <= 1'b0;
            end
        end
    end

    assign o_ok               = r_ok;
    assign o_cost_fits        = r_fits;
    assign o_attacker_count   = r_count;
    assign o_tokens_available = r_pool;

endmodule

// ----- sim/credit_token_allocator_test.sv -----
// ----------------------------------------------------------------------------
// credit_token_allocator_test
// drives requests and releases into the token allocator through start/busy,
// predicts the pool level, holder count and grant outcome of every
// transaction, and compares each strobed result with the oldest prediction
// ----------------------------------------------------------------------------
module credit_token_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cta_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned PHASE_ITEMS = 205;

    typedef struct packed {
        logic               ok;
        logic               cost_fits;
        logic [COUNT_W-1:0] holders;
        logic [FIELD_W-1:0] level;
    } t_token_result;

    class t_token_scoreboard;
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] pool;
        logic [COUNT_W-1:0] holders;
        logic [FIELD_W-1:0] held [ID_SPAN];
        bit                 holding [ID_SPAN];
        t_token_result      outcomes [$];
        int                 errors;

        function new();
            total   = TOTAL_RESET;
            pool    = TOTAL_RESET;
            holders = '0;
            errors  = 0;
            for (int i = 0; i < ID_SPAN; i++) begin
                held[i]    = '0;
                holding[i] = 1'b0;
            end
        endfunction

        function void set_total(logic [FIELD_W-1:0] value);
            total = value;
            pool  = value;
        endfunction

        function bit return_holding(logic [ID_W-1:0] id);
            logic [FIELD_W:0] sum;
            if (!holding[id]) begin
                return 1'b0;
            end
            sum = {1'b0, pool} + {1'b0, held[id]};
            if (sum > {1'b0, total}) begin
                return 1'b0;
            end
            pool        = sum[FIELD_W-1:0];
            held[id]    = '0;
            holding[id] = 1'b0;
            if (holders != 0) begin
                holders = holders - 1'b1;
            end
            return 1'b1;
        endfunction

        function void record_request(logic func, logic [ID_W-1:0] id, logic live,
                                     logic [FIELD_W-1:0] cost);
            t_token_result r;
            r = '0;
            if (func == FUNC_REQUEST) begin
                r.cost_fits = (pool != 0) && (pool >= cost);
                if (live) begin
                    void'(return_holding(id));
                    if (pool != 0 && pool >= cost) begin
                        pool = pool - cost;
                        if (!holding[id]) begin
                            holding[id] = 1'b1;
                            holders     = holders + 1'b1;
                        end
                        held[id] = cost;
                        r.ok     = 1'b1;
                    end
                end
            end else if (live) begin
                r.ok = return_holding(id);
            end
            r.holders = holders;
            r.level   = pool;
            outcomes.push_back(r);
        endfunction

        function void check_result(t_token_result got);
            t_token_result want;
            if (outcomes.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result ok=%0d fits=%0d count=%0d tokens=%0d",
                             got.ok, got.cost_fits, got.holders, got.level);
                end
                return;
            end
            want = outcomes.pop_front();
            if (got.ok !== want.ok || got.cost_fits !== want.cost_fits ||
                got.holders !== want.holders || got.level !== want.level) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp ok/fits/cnt/tok %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.ok, want.cost_fits, want.holders, want.level,
                             got.ok, got.cost_fits, got.holders, got.level);
                end
            end
        endfunction

        function int pending();
            return outcomes.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [ID_W-1:0]    i_client_id;
    logic               i_client_live;
    logic [FIELD_W-1:0] i_cost;
    logic               i_cfg_we;
    logic [FIELD_W-1:0] i_cfg_wdata;
    logic               o_valid;
    logic               o_ok;
    logic               o_cost_fits;
    logic [COUNT_W-1:0] o_attacker_count;
    logic [FIELD_W-1:0] o_tokens_available;

    t_token_scoreboard  sb;
    int unsigned        gap_max;
    int unsigned        cycles = 0;

    credit_token_allocator u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_client_id        (i_client_id),
        .i_client_live      (i_client_live),
        .i_cost             (i_cost),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_ok               (o_ok),
        .o_cost_fits        (o_cost_fits),
        .o_attacker_count   (o_attacker_count),
        .o_tokens_available (o_tokens_available)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result({o_ok, o_cost_fits, o_attacker_count, o_tokens_available});
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic func, logic [ID_W-1:0] id, logic live,
                             logic [FIELD_W-1:0] cost);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        repeat (gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_client_id   <= id;
        i_client_live <= live;
        i_cost        <= cost;
        do @(posedge i_clk); while (busy);
        sb.record_request(func, id, live, cost);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic               func;
        logic [ID_W-1:0]    id;
        logic               live;
        logic [FIELD_W-1:0] cost;
        int unsigned        pick;
        func = ($urandom_range(0, 99) < 45) ? FUNC_RELEASE : FUNC_REQUEST;
        id   = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3))
                                           : ID_W'($urandom_range(0, 15));
        live = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            cost = FIELD_W'($urandom_range(0, sb.total >> 2));
        end else if (pick < 7) begin
            cost = FIELD_W'($urandom_range(0, sb.total));
        end else if (pick == 7) begin
            cost = '0;
        end else if (pick == 8) begin
            cost = FIELD_W'($urandom);
        end else begin
            cost = '1;
        end
        send_item(func, id, live, cost);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_total(logic [FIELD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_total(value);
        @(negedge i_clk);
    endtask

    initial begin
        logic [FIELD_W-1:0] totals [8];
        sb            = new();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_func        = FUNC_REQUEST;
        i_client_id   = '0;
        i_client_live = 1'b0;
        i_cost        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        gap_max       = 3;
        totals        = '{8'd8, 8'd255, 8'd0, 8'd1, 8'd128, 8'd255, 8'd2, 8'd0};
        totals[4]     = FIELD_W'($urandom);
        totals[7]     = FIELD_W'($urandom_range(3, 254));
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: non-holder release, zero cost, exhaustion, stale clients
        send_item(FUNC_RELEASE, 4'd0,  1'b1, 8'd0);
        send_item(FUNC_REQUEST, 4'd0,  1'b1, 8'd0);
        send_item(FUNC_REQUEST, 4'd15, 1'b1, 8'd8);
        send_item(FUNC_REQUEST, 4'd1,  1'b1, 8'd0);
        send_item(FUNC_REQUEST, 4'd2,  1'b0, 8'd0);
        send_item(FUNC_RELEASE, 4'd15, 1'b1, 8'd255);
        send_item(FUNC_REQUEST, 4'd3,  1'b1, 8'd255);
        send_item(FUNC_RELEASE, 4'd0,  1'b0, 8'd0);
        send_item(FUNC_REQUEST, 4'd3,  1'b1, 8'd5);
        send_item(FUNC_REQUEST, 4'd3,  1'b1, 8'd3);
        send_item(FUNC_REQUEST, 4'd9,  1'b0, 8'd170);
        // refill keeps holdings, so the give-back of client 3 is refused
        wait_idle();
        write_total(8'd8);
        send_item(FUNC_RELEASE, 4'd3,  1'b1, 8'd0);
        send_item(FUNC_REQUEST, 4'd3,  1'b1, 8'd2);
        send_item(FUNC_RELEASE, 4'd0,  1'b1, 8'd0);
        send_item(FUNC_RELEASE, 4'd3,  1'b1, 8'd0);
        send_item(FUNC_REQUEST, 4'd15, 1'b1, 8'd7);

        foreach (totals[p]) begin
            if (p != 0) begin
                wait_idle();
                write_total(totals[p]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
                end
                send_random();
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
